### hw/rtl/dstnp_pkg.sv
// shared types and constants of the decimal string parser
// character codes, field widths, parse phase type and the scan-to-format record
// no dependencies
package dstnp_pkg;

    // defaults for the top-level parameters
    localparam int SIG_DIGITS_DEF = 18;
    localparam int EXP_LIMIT_DEF  = 9999;

    // field and state widths
    localparam int CHAR_W   = 8;
    localparam int MAG_W    = 60;
    localparam int CNT_W    = 5;
    localparam int EXPV_W   = 14;
    localparam int SCALE_W  = 15;
    localparam int SIG_W    = 61;
    localparam int DEXP_W   = 16;
    localparam int SUM_W    = 17;
    localparam int M_DATA_W = 80;
    localparam int PAD_W    = M_DATA_W - SIG_W - DEXP_W;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // parse phase
    typedef enum logic [3:0] {
        PH_WS,
        PH_SIGN,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_E,
        PH_ESIGN,
        PH_EDIG,
        PH_DONE
    } t_phase;

    // end-of-string record handed from scan to format
    typedef struct packed {
        logic                      err;
        logic                      neg;
        logic [MAG_W-1:0]          mag;
        logic                      exp_neg;
        logic [EXPV_W-1:0]         exp_val;
        logic signed [SCALE_W-1:0] scale;
    } t_raw;

endpackage

### hw/rtl/dstnp_scan.sv
// character scanner: parse phase machine, digit accumulation, exponent digits
// closes a string into a t_raw record held in its own register
// depends on dstnp_pkg
module dstnp_scan #(
    parameter int SIG_DIGITS = dstnp_pkg::SIG_DIGITS_DEF,
    parameter int EXP_LIMIT  = dstnp_pkg::EXP_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_char_valid,
    input  logic [dstnp_pkg::CHAR_W-1:0]  i_char,
    input  logic                          i_last,
    output logic                          o_char_take,
    input  logic                          i_raw_ready,
    output logic                          o_raw_valid,
    output dstnp_pkg::t_raw               o_raw
);
    import dstnp_pkg::*;

    localparam logic signed [SCALE_W:0] SCALE_HI = (SCALE_W+1)'(EXP_LIMIT);
    localparam logic signed [SCALE_W:0] SCALE_LO = -(SCALE_W+1)'(EXP_LIMIT);
    localparam logic [EXPV_W+3:0]       EXPV_HI  = (EXPV_W+4)'(EXP_LIMIT);
    localparam logic [CNT_W-1:0]        CNT_MAX  = CNT_W'(SIG_DIGITS);

    // state registers
    t_phase                     r_phase, n_phase;
    logic [MAG_W-1:0]           r_mag, n_mag;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_neg, n_neg;
    logic                       r_saw_int, n_saw_int;
    logic [EXPV_W-1:0]          r_exp_val, n_exp_val;
    logic                       r_exp_neg, n_exp_neg;
    logic signed [SCALE_W-1:0]  r_scale, n_scale;

    logic                       r_raw_valid;
    t_raw                       r_raw, n_raw;

    // character classes
    logic                       is_digit, is_space, is_sign, is_e, is_dot, is_minus;
    logic [3:0]                 digit;
    logic                       do_int, do_frac, do_exp, lead_zero, take_last;
    logic [MAG_W-1:0]           mag_x10;
    logic [EXPV_W+3:0]          exp_x10;
    logic signed [SCALE_W:0]    scale_up, scale_dn;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign is_minus = (i_char == CH_MINUS);
    assign is_sign  = (i_char == CH_PLUS) || is_minus;
    assign is_e     = (i_char == CH_LOW_E) || (i_char == CH_UP_E);
    assign is_dot   = (i_char == CH_DOT);
    assign digit    = is_digit ? 4'(i_char - CH_ZERO) : 4'd0;

    // a closing beat waits for room in the record register
    assign o_char_take = i_char_valid && (!i_last || !r_raw_valid || i_raw_ready);
    assign take_last   = o_char_take && i_last;

    // next phase
    always_comb begin
        n_phase = PH_DONE;
        unique case (r_phase)
            PH_WS, PH_SIGN: begin
                if (r_phase == PH_WS && is_space) n_phase = PH_WS;
                else if (r_phase == PH_WS && is_sign) n_phase = PH_SIGN;
                else if (is_digit) n_phase = PH_INT;
                else if (is_dot) n_phase = PH_DOT;
                else if (is_e) n_phase = PH_E;
            end
            PH_INT: begin
                if (is_digit) n_phase = PH_INT;
                else if (is_dot) n_phase = PH_DOT;
                else if (is_e) n_phase = PH_E;
            end
            PH_DOT, PH_FRAC: begin
                if (is_digit) n_phase = PH_FRAC;
                else if (is_e) n_phase = PH_E;
            end
            PH_E, PH_ESIGN, PH_EDIG: begin
                if (r_phase == PH_E && is_sign) n_phase = PH_ESIGN;
                else if (is_digit) n_phase = PH_EDIG;
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    // which unit a digit goes to
    assign do_int  = is_digit && (r_phase == PH_WS || r_phase == PH_SIGN || r_phase == PH_INT);
    assign do_frac = is_digit && (r_phase == PH_DOT || r_phase == PH_FRAC);
    assign do_exp  = is_digit && (r_phase == PH_E || r_phase == PH_ESIGN || r_phase == PH_EDIG);

    // times ten and add, scale step candidates
    assign mag_x10   = (r_mag << 3) + (r_mag << 1) + MAG_W'(digit);
    assign exp_x10   = ((EXPV_W+4)'(r_exp_val) << 3) + ((EXPV_W+4)'(r_exp_val) << 1)
                     + (EXPV_W+4)'(digit);
    assign scale_up  = (SCALE_W+1)'(r_scale) + (SCALE_W+1)'(1);
    assign scale_dn  = (SCALE_W+1)'(r_scale) - (SCALE_W+1)'(1);
    assign lead_zero = (r_mag == '0) && (digit == 4'd0);

    // state updates for one character
    always_comb begin
        n_mag     = r_mag;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_saw_int = r_saw_int;
        n_exp_val = r_exp_val;
        n_exp_neg = r_exp_neg;
        n_scale   = r_scale;

        if (r_phase == PH_WS && is_sign) begin
            n_neg = is_minus;
        end
        if (r_phase == PH_E && is_sign) begin
            n_exp_neg = is_minus;
        end
        if (do_int) begin
            n_saw_int = 1'b1;
        end

        // significand digits
        if (do_int || do_frac) begin
            if (lead_zero) begin
                if (do_frac) n_scale = (scale_dn < SCALE_LO) ? SCALE_W'(SCALE_LO)
                                                             : SCALE_W'(scale_dn);
            end else if (r_cnt < CNT_MAX) begin
                n_mag = mag_x10;
                n_cnt = r_cnt + CNT_W'(1);
                if (do_frac) n_scale = (scale_dn < SCALE_LO) ? SCALE_W'(SCALE_LO)
                                                             : SCALE_W'(scale_dn);
            end else if (do_int) begin
                n_scale = (scale_up > SCALE_HI) ? SCALE_W'(SCALE_HI) : SCALE_W'(scale_up);
            end
        end

        // exponent digits, saturating
        if (do_exp) begin
            n_exp_val = (exp_x10 > EXPV_HI) ? EXPV_W'(EXPV_HI) : EXPV_W'(exp_x10);
        end
    end

    // record for the closing beat
    always_comb begin
        n_raw.err     = (n_phase == PH_WS) || (n_phase == PH_SIGN) || (n_phase == PH_E)
                     || (n_phase == PH_ESIGN) || ((n_phase == PH_DOT) && !n_saw_int);
        n_raw.neg     = n_neg;
        n_raw.mag     = n_mag;
        n_raw.exp_neg = n_exp_neg;
        n_raw.exp_val = n_exp_val;
        n_raw.scale   = n_scale;
    end

    // parse state, back to start after the closing beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || take_last) begin
            r_phase   <= PH_WS;
            r_mag     <= '0;
            r_cnt     <= '0;
            r_neg     <= 1'b0;
            r_saw_int <= 1'b0;
            r_exp_val <= '0;
            r_exp_neg <= 1'b0;
            r_scale   <= '0;
        end else if (o_char_take) begin
            r_phase   <= n_phase;
            r_mag     <= n_mag;
            r_cnt     <= n_cnt;
            r_neg     <= n_neg;
            r_saw_int <= n_saw_int;
            r_exp_val <= n_exp_val;
            r_exp_neg <= n_exp_neg;
            r_scale   <= n_scale;
        end
    end

    // record register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_valid <= 1'b0;
        end else if (take_last) begin
            r_raw_valid <= 1'b1;
        end else if (i_raw_ready) begin
            r_raw_valid <= 1'b0;
        end
    end

    // record register payload
    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_raw <= n_raw;
        end
    end

    assign o_raw_valid = r_raw_valid;
    assign o_raw       = r_raw;

endmodule

### hw/rtl/dstnp_format.sv
// result formatter: signs the significand, combines exponent and scale with saturation
// holds the output register of the master side
// depends on dstnp_pkg
module dstnp_format #(
    parameter int EXP_LIMIT = dstnp_pkg::EXP_LIMIT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_raw_valid,
    input  dstnp_pkg::t_raw                      i_raw,
    output logic                                 o_raw_ready,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_status,
    output logic signed [dstnp_pkg::SIG_W-1:0]   o_sig,
    output logic signed [dstnp_pkg::DEXP_W-1:0]  o_dexp
);
    import dstnp_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(2 * EXP_LIMIT + 1);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(2 * EXP_LIMIT + 1);

    logic                      r_valid;
    logic                      r_status, n_status;
    logic signed [SIG_W-1:0]   r_sig, n_sig;
    logic signed [DEXP_W-1:0]  r_dexp, n_dexp;
    logic signed [SUM_W-1:0]   exp_signed, exp_sum;
    logic                      load;

    assign o_raw_ready = !r_valid || i_ready;
    assign load        = i_raw_valid && o_raw_ready;

    // exponent plus scale
    assign exp_signed = i_raw.exp_neg ? -SUM_W'(i_raw.exp_val) : SUM_W'(i_raw.exp_val);
    assign exp_sum    = exp_signed + SUM_W'(i_raw.scale);

    // result fields, zero on an error ending
    always_comb begin
        n_status = i_raw.err;
        n_sig    = '0;
        n_dexp   = '0;
        if (!i_raw.err) begin
            n_sig = i_raw.neg ? -SIG_W'(i_raw.mag) : SIG_W'(i_raw.mag);
            priority if (exp_sum > SUM_HI) n_dexp = DEXP_W'(SUM_HI);
            else if (exp_sum < SUM_LO)     n_dexp = DEXP_W'(SUM_LO);
            else                           n_dexp = DEXP_W'(exp_sum);
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
            r_sig    <= n_sig;
            r_dexp   <= n_dexp;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_sig    = r_sig;
    assign o_dexp   = r_dexp;

endmodule

### hw/rtl/decimal_string_to_number_parser.sv
// channel   dir  beat contents
// s_axis    in   tdata[7:0] char_code, tlast last_char
// m_axis    out  tdata[60:0] significand, [76:61] decimal_exponent, tuser parse_status
//
// one character per cycle while m_axis is not stalled; the result of a string passes the
// input register, the scan record register and the output register after the beat with tlast
// the scan state update (times ten and add on the digit magnitude) sets the rate
// synchronous active-low reset returns the parser to leading-whitespace phase
// each stage holds while the next is full and stalled; s_axis_tready falls only while
// a closing beat waits in the input register with record and output full behind a stalled m_axis
//
// top level of the decimal string parser: input register and stage hookup
// depends on dstnp_pkg, dstnp_scan, dstnp_format
module decimal_string_to_number_parser #(
    parameter int SIG_DIGITS = dstnp_pkg::SIG_DIGITS_DEF,
    parameter int EXP_LIMIT  = dstnp_pkg::EXP_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dstnp_pkg::CHAR_W-1:0]       s_axis_tdata,   // [7:0] char_code
    input  logic                               s_axis_tlast,   // last_char
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [dstnp_pkg::M_DATA_W-1:0]     m_axis_tdata,   // [60:0] significand,
                                                               // [76:61] decimal_exponent
    output logic                               m_axis_tuser    // parse_status
);
    import dstnp_pkg::*;

    logic                       r_in_valid;
    logic [CHAR_W-1:0]          r_in_char;
    logic                       r_in_last;
    logic                       char_take;
    logic                       raw_valid, raw_ready;
    t_raw                       raw;
    logic signed [SIG_W-1:0]    res_sig;
    logic signed [DEXP_W-1:0]   res_dexp;

    assign s_axis_tready = !r_in_valid || char_take;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // character scanner
    dstnp_scan #(
        .SIG_DIGITS (SIG_DIGITS),
        .EXP_LIMIT  (EXP_LIMIT)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (r_in_valid),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .o_char_take  (char_take),
        .i_raw_ready  (raw_ready),
        .o_raw_valid  (raw_valid),
        .o_raw        (raw)
    );

    // result formatter
    dstnp_format #(
        .EXP_LIMIT (EXP_LIMIT)
    ) u_format (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw_valid (raw_valid),
        .i_raw       (raw),
        .o_raw_ready (raw_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_sig       (res_sig),
        .o_dexp      (res_dexp)
    );

    // master beat packing
    assign m_axis_tdata = {PAD_W'(0), res_dexp, res_sig};

endmodule

### hw/rtl/dstnp_checker.sv
// port-level checks on the decimal string parser
// bound to decimal_string_to_number_parser; depends on dstnp_pkg
module dstnp_checker #(
    parameter int EXP_LIMIT = dstnp_pkg::EXP_LIMIT_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dstnp_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);
    import dstnp_pkg::*;

    localparam logic signed [DEXP_W-1:0] DEXP_HI = DEXP_W'(2 * EXP_LIMIT + 1);
    localparam logic signed [DEXP_W-1:0] DEXP_LO = -DEXP_W'(2 * EXP_LIMIT + 1);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // an error ending carries zero significand and exponent
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with non-zero fields");

    // exponent stays within its saturation bounds
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[SIG_W+DEXP_W-1:SIG_W]) <= DEXP_HI)
                       && ($signed(m_axis_tdata[SIG_W+DEXP_W-1:SIG_W]) >= DEXP_LO))
        else $error("decimal exponent beyond saturation bound");

    // padding bits of the result beat stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_DATA_W-1:SIG_W+DEXP_W] == '0)
        else $error("padding bits set in result beat");

    // with the output side free the input side keeps taking beats
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !$past(m_axis_tvalid) && !$past(s_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled with an empty pipeline");

endmodule

bind decimal_string_to_number_parser dstnp_checker #(
    .EXP_LIMIT (EXP_LIMIT)
) u_dstnp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for decimal_string_to_number_parser: character beats in, numbers out
// depends on dstnp_pkg and the parser rtl
module tb_top;
    import dstnp_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_CYC   = 9;
    localparam int SIG_KEEP    = SIG_DIGITS_DEF;
    localparam int EXP_CAP     = EXP_LIMIT_DEF;
    localparam int IDLE_PCT    = 38;
    localparam int CALM_FROM   = 1200;
    localparam int CALM_TO     = 3200;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYC   = 12;
    localparam int RAND_CHARS  = 1480;
    localparam int LONG_RUN    = 30;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_beat;

    typedef struct packed {
        logic              status;
        logic [SIG_W-1:0]  sig;
        logic [DEXP_W-1:0] dexp;
    } t_number;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata = '0;   // [7:0] char_code
    logic                  s_axis_tlast = 1'b0; // last_char
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;        // [60:0] significand, [76:61] decimal_exponent
    logic                  m_axis_tuser;        // parse_status

    t_char_beat  char_queue[$];
    t_number     expected_numbers[$];
    logic [7:0]  word_q[$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int          cyc_count = 0;
    int          quiet_cycles = 0;

    // predictor state
    t_phase            ph_q;
    logic [MAG_W-1:0]  mag_q;
    int                kept_q;
    bit                neg_q;
    bit                saw_int_q;
    int                expv_q;
    bit                exp_neg_q;
    int                scale_q;

    decimal_string_to_number_parser #(
        .SIG_DIGITS(SIG_KEEP),
        .EXP_LIMIT (EXP_CAP)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function void clear_parse();
        ph_q      = PH_WS;
        mag_q     = '0;
        kept_q    = 0;
        neg_q     = 1'b0;
        saw_int_q = 1'b0;
        expv_q    = 0;
        exp_neg_q = 1'b0;
        scale_q   = 0;
    endfunction

    function void nudge_scale(int step);
        scale_q = scale_q + step;
        if (scale_q > EXP_CAP) scale_q = EXP_CAP;
        if (scale_q < -EXP_CAP) scale_q = -EXP_CAP;
    endfunction

    // leading zeros are skipped; beyond the kept digits, integer digits only shift the scale
    function void take_digit(int d, bit frac);
        if (mag_q == '0 && d == 0) begin
            if (frac) nudge_scale(-1);
        end else if (kept_q < SIG_KEEP) begin
            mag_q  = mag_q * 10 + MAG_W'(d);
            kept_q = kept_q + 1;
            if (frac) nudge_scale(-1);
        end else if (!frac) begin
            nudge_scale(1);
        end
    endfunction

    function void parse_char(logic [CHAR_W-1:0] c, logic last);
        bit     dig;
        bit     spc;
        bit     sgn;
        bit     is_e;
        int     d;
        int     ex;
        bit     err;
        t_phase nxt;
        t_number num;
        dig  = c >= CH_ZERO && c <= CH_NINE;
        spc  = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        sgn  = c == CH_PLUS || c == CH_MINUS;
        is_e = c == CH_LOW_E || c == CH_UP_E;
        d    = dig ? int'(c - CH_ZERO) : 0;
        nxt  = PH_DONE;
        case (ph_q)
            PH_WS, PH_SIGN: begin
                if (ph_q == PH_WS && spc) begin
                    nxt = PH_WS;
                end else if (ph_q == PH_WS && sgn) begin
                    neg_q = c == CH_MINUS;
                    nxt   = PH_SIGN;
                end else if (dig) begin
                    saw_int_q = 1'b1;
                    take_digit(d, 1'b0);
                    nxt = PH_INT;
                end else if (c == CH_DOT) begin
                    nxt = PH_DOT;
                end else if (is_e) begin
                    nxt = PH_E;
                end
            end
            PH_INT: begin
                if (dig) begin
                    take_digit(d, 1'b0);
                    nxt = PH_INT;
                end else if (c == CH_DOT) begin
                    nxt = PH_DOT;
                end else if (is_e) begin
                    nxt = PH_E;
                end
            end
            PH_DOT, PH_FRAC: begin
                if (dig) begin
                    take_digit(d, 1'b1);
                    nxt = PH_FRAC;
                end else if (is_e) begin
                    nxt = PH_E;
                end
            end
            PH_E, PH_ESIGN, PH_EDIG: begin
                if (ph_q == PH_E && sgn) begin
                    exp_neg_q = c == CH_MINUS;
                    nxt = PH_ESIGN;
                end else if (dig) begin
                    expv_q = expv_q * 10 + d;
                    if (expv_q > EXP_CAP) expv_q = EXP_CAP;
                    nxt = PH_EDIG;
                end
            end
            default: begin
                nxt = PH_DONE;
            end
        endcase
        ph_q = nxt;
        if (last) begin
            err = nxt == PH_WS || nxt == PH_SIGN || nxt == PH_E || nxt == PH_ESIGN ||
                  (nxt == PH_DOT && !saw_int_q);
            num = '0;
            num.status = err;
            if (!err) begin
                ex = exp_neg_q ? -expv_q : expv_q;
                ex = ex + scale_q;
                if (ex > 2 * EXP_CAP + 1) ex = 2 * EXP_CAP + 1;
                if (ex < -(2 * EXP_CAP + 1)) ex = -(2 * EXP_CAP + 1);
                num.sig  = neg_q ? -{1'b0, mag_q} : {1'b0, mag_q};
                num.dexp = DEXP_W'(ex);
            end
            expected_numbers.push_back(num);
            clear_parse();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // moves the string being built into the beat queue, flagging its final character
    function void flush_word();
        t_char_beat beat;
        foreach (word_q[i]) begin
            beat.code = word_q[i];
            beat.last = i == word_q.size() - 1;
            char_queue.push_back(beat);
        end
        word_q.delete();
    endfunction

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
        flush_word();
    endfunction

    function logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function logic [7:0] rand_sign();
        return $urandom_range(1) ? CH_MINUS : CH_PLUS;
    endfunction

    function void push_digits(int n);
        repeat (n) word_q.push_back(rand_digit());
    endfunction

    // number text with random content, not always well-formed, sometimes with trailing junk
    function void build_number();
        repeat ($urandom_range(2)) begin
            word_q.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        end
        if ($urandom_range(2) != 0) word_q.push_back(rand_sign());
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) word_q.push_back(CH_ZERO);
        push_digits(($urandom_range(4) == 0) ? $urandom_range(15, 24) : $urandom_range(5));
        if ($urandom_range(2) != 0) begin
            word_q.push_back(CH_DOT);
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) word_q.push_back(CH_ZERO);
            push_digits(($urandom_range(5) == 0) ? $urandom_range(12, 22) : $urandom_range(5));
        end
        if ($urandom_range(2) != 0) begin
            word_q.push_back($urandom_range(1) ? CH_LOW_E : CH_UP_E);
            if ($urandom_range(2) != 0) word_q.push_back(rand_sign());
            push_digits($urandom_range(6));
        end
        if (word_q.size() == 0) word_q.push_back(rand_digit());
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) word_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    function bit take_break();
        if (cyc_count >= CALM_FROM && cyc_count < CALM_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] result %0d: %s", $realtime, result_count, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin : drive_chars
        t_char_beat beat;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) parse_char(s_axis_tdata, s_axis_tlast);
            if (char_queue.size() != 0 && !take_break()) begin
                beat = char_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= beat.code;
                s_axis_tlast  <= beat.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : watch_numbers
        t_number got;
        t_number want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.sig    = m_axis_tdata[SIG_W-1:0];
                got.dexp   = m_axis_tdata[SIG_W+DEXP_W-1:SIG_W];
                if (expected_numbers.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_numbers.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0b want %0b",
                                                  got.status, want.status));
                    if (got.sig !== want.sig)
                        report_mismatch($sformatf("significand got %0d want %0d",
                                                  $signed(got.sig), $signed(want.sig)));
                    if (got.dexp !== want.dexp)
                        report_mismatch($sformatf("exponent got %0d want %0d",
                                                  $signed(got.dexp), $signed(want.dexp)));
                end
                result_count++;
            end
            m_axis_tready <= !take_break();
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_parse();

        // error endings and other edge cases: early dot and exponent, non-fitting characters
        push_text(" ");
        push_text("-");
        push_text(".");
        push_text("E");
        push_text("1e+");
        push_text("3.");
        word_q.push_back(8'h00);
        flush_word();
        word_q.push_back(8'hFF);
        flush_word();
        push_text("-.5");
        push_text("2x9");
        push_text("\t+8");

        // mostly well-formed, some cut short, some plain noise
        while (char_queue.size() < RAND_CHARS) begin
            case ($urandom_range(19))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4)) word_q.push_back(8'($urandom_range(255)));
                end
                3, 4, 5: begin
                    build_number();
                    while (word_q.size() > 1 && $urandom_range(2) != 0) void'(word_q.pop_back());
                end
                default: begin
                    build_number();
                end
            endcase
            flush_word();
        end

        // widest significand with dropped digits, exponent digits at their limit and saturated negative
        word_q.push_back(CH_MINUS);
        repeat (LONG_RUN) word_q.push_back(CH_NINE);
        push_text("e9999");
        push_text("0.");
        repeat (LONG_RUN) word_q.push_back(CH_ZERO);
        push_text("1e-99999");

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
